// ===== rtl/sspr_pkg.sv =====
package sspr_pkg;

    localparam int DELAY_TABLE_DEPTH_DEF = 2048;
    localparam int COMMAND_LENGTH = 7;
    localparam int MODE_POS = 3;
    localparam int MAX_DELAY = 226;
    localparam int SEARCH_STEPS = 8;

    localparam logic [1:0] OP_BYTE = 2'd0;
    localparam logic [1:0] OP_RAMP = 2'd1;
    localparam logic [1:0] OP_MS = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [7:0] MODE_RIGHT = 8'h64;
    localparam logic [7:0] MODE_LEFT = 8'h69;
    localparam logic [7:0] MODE_STOP = 8'h70;
    localparam logic [7:0] MODE_NONE = 8'h00;

    localparam logic [10:0] STOP_FLOOR = 11'd5;

    // Measured rpm is pulses * 6 / 5, taken as (pulses * 6 * ceil(2^21 / 5)) >> 21.
    localparam int RPM_MULT = 2516586;
    localparam int RPM_SHIFT = 21;

    localparam int RES_W = 85;
    localparam int TDATA_OUT_W = 88;

    localparam real THR_EXP = 50.0 / 47.0;

    typedef logic [9:0] thr_tab_t [0:255];

    typedef struct packed {
        logic capture;
        logic apply_simple;
        logic div_start;
        logic ramp_apply;
        logic search_step;
        logic delay_apply;
    } cmd_t;

    typedef struct packed {
        logic op_is_ramp;
        logic div_done;
        logic search_done;
    } sts_t;

    // Entry d holds the largest ramp value a that still gives a delay of at least d.
    function automatic thr_tab_t build_thr();
        thr_tab_t t;
        real r;
        for (int d = 0; d < 256; d++) begin
            if (d == 0 || d > MAX_DELAY) begin
                t[d] = '0;
            end else begin
                r = $exp(THR_EXP * ($ln(226.8) - $ln(real'(d))));
                t[d] = 10'($rtoi(r));
            end
        end
        return t;
    endfunction

    localparam thr_tab_t DELAY_THR = build_thr();

    function automatic logic [3:0] to_digit(input logic [7:0] b);
        logic [3:0] d;
        if (b < 8'h30) begin
            d = 4'd0;
        end else if (b > 8'h39) begin
            d = 4'd9;
        end else begin
            d = 4'(b - 8'h30);
        end
        return d;
    endfunction

    function automatic logic [3:0] coil_for(input logic [1:0] p, input logic rev);
        logic [1:0] idx;
        idx = rev ? ~p : p;
        return 4'b0001 << idx;
    endfunction

endpackage

// ===== rtl/sspr_div.sv =====
module sspr_div #(
    parameter int NW = 19,
    parameter int DW = 10
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [NW-1:0] quo
);
    localparam int CW = $clog2(NW + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [NW-1:0] q_reg, q_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [DW-1:0] den_reg, den_next;
    logic [DW:0]   sh;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next = cnt_reg;
        q_next = q_reg;
        rem_next = rem_reg;
        den_next = den_reg;
        sh = {rem_reg, q_reg[NW-1]};
        if (start) begin
            busy_next = 1'b1;
            cnt_next = CW'(NW);
            q_next = num;
            rem_next = '0;
            den_next = den;
        end else if (busy_reg) begin
            if (sh >= {1'b0, den_reg}) begin
                rem_next = DW'(sh - {1'b0, den_reg});
                q_next = {q_reg[NW-2:0], 1'b1};
            end else begin
                rem_next = sh[DW-1:0];
                q_next = {q_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
        q_reg <= q_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quo = q_reg;
endmodule

// ===== rtl/sspr_ctrl.sv =====
module sspr_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    input  logic          out_free,
    input  sspr_pkg::sts_t sts,
    output logic          in_ready,
    output logic          out_load,
    output sspr_pkg::cmd_t cmd
);
    import sspr_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_DISPATCH = 6'b000010,
        ST_DIV_INC  = 6'b000100,
        ST_SEARCH   = 6'b001000,
        ST_DONE     = 6'b010000,
        ST_SPARE    = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        out_load = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    cmd.capture = 1'b1;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                if (sts.op_is_ramp) begin
                    cmd.div_start = 1'b1;
                    state_next = ST_DIV_INC;
                end else begin
                    cmd.apply_simple = 1'b1;
                    state_next = ST_DONE;
                end
            end
            ST_DIV_INC: begin
                if (sts.div_done) begin
                    cmd.ramp_apply = 1'b1;
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (sts.search_done) begin
                    cmd.delay_apply = 1'b1;
                    state_next = ST_DONE;
                end else begin
                    cmd.search_step = 1'b1;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    out_load = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);
endmodule

// ===== rtl/sspr_dpath.sv =====
module sspr_dpath #(
    parameter int DELAY_TABLE_DEPTH = sspr_pkg::DELAY_TABLE_DEPTH_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  sspr_pkg::cmd_t            cmd,
    output sspr_pkg::sts_t            sts,
    input  logic [1:0]                in_op,
    input  logic [7:0]                in_byte,
    input  logic [15:0]               in_pulses,
    output logic [sspr_pkg::RES_W-1:0] res_data,
    output logic                      res_report
);
    import sspr_pkg::*;

    localparam int AW = $clog2(DELAY_TABLE_DEPTH);
    localparam logic [AW-1:0] A_LAST = AW'(DELAY_TABLE_DEPTH - 1);
    localparam int IW = (AW > 11) ? AW : 11;

    logic [1:0]  op_reg, op_next;
    logic [7:0]  byte_reg, byte_next;
    logic        rep_reg, rep_next;
    logic [16:0] rpm_reg, rpm_next;
    logic        move_reg, move_next;
    logic [7:0]  lo_reg, lo_next;
    logic [7:0]  hi_reg, hi_next;
    logic [3:0]  cnt_reg, cnt_next;

    logic [2:0]  pos_reg, pos_next;
    logic [3:0]  dig_reg [0:5];
    logic [3:0]  dig_next [0:5];
    logic [7:0]  mode_reg, mode_next;
    logic [9:0]  tgt_reg, tgt_next;
    logic [9:0]  len_reg, len_next;
    logic [10:0] ramp_reg, ramp_next;
    logic [7:0]  delay_reg, delay_next;
    logic [15:0] chg_reg, chg_next;
    logic [1:0]  ph_reg, ph_next;
    logic [7:0]  hold_reg, hold_next;
    logic        act_reg, act_next;
    logic        gap_reg, gap_next;
    logic        rev_reg, rev_next;
    logic [3:0]  coil_reg, coil_next;

    logic [9:0]  div_num;
    logic [9:0]  div_den;
    logic [9:0]  div_q;
    logic        div_done;

    logic [37:0] rpm_prod;
    logic [2:0]  pos;
    logic [2:0]  pos_inc;
    logic [9:0]  len_eff;
    logic [9:0]  inc;
    logic [7:0]  hold_val;
    logic        run;
    logic [8:0]  mid;
    logic [IW-1:0] a_ext;
    logic [IW-1:0] a_idx;

    assign len_eff = (len_reg == 10'd0) ? 10'd1 : len_reg;
    assign div_num = tgt_reg;
    assign div_den = len_eff;
    assign rpm_prod = {22'd0, in_pulses} * 38'(RPM_MULT);

    sspr_div #(.NW(10), .DW(10)) u_div (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (cmd.div_start),
        .num    (div_num),
        .den    (div_den),
        .done   (div_done),
        .quo    (div_q)
    );

    assign hold_val = (delay_reg == 8'd0) ? 8'd1 : delay_reg;
    assign inc = div_q;
    assign a_ext = IW'(ramp_reg);
    assign a_idx = (a_ext > IW'(A_LAST)) ? IW'(A_LAST) : a_ext;
    assign mid = 9'(({1'b0, lo_reg} + {1'b0, hi_reg} + 9'd1) >> 1);

    always_comb begin
        op_next = op_reg;
        byte_next = byte_reg;
        rep_next = rep_reg;
        rpm_next = rpm_reg;
        move_next = move_reg;
        lo_next = lo_reg;
        hi_next = hi_reg;
        cnt_next = cnt_reg;
        pos_next = pos_reg;
        dig_next = dig_reg;
        mode_next = mode_reg;
        tgt_next = tgt_reg;
        len_next = len_reg;
        ramp_next = ramp_reg;
        delay_next = delay_reg;
        chg_next = chg_reg;
        ph_next = ph_reg;
        hold_next = hold_reg;
        act_next = act_reg;
        gap_next = gap_reg;
        rev_next = rev_reg;
        coil_next = coil_reg;
        run = 1'b0;
        pos = (pos_reg >= 3'(COMMAND_LENGTH)) ? 3'd0 : pos_reg;
        pos_inc = pos + 3'd1;

        if (cmd.capture) begin
            op_next = in_op;
            byte_next = in_byte;
            rpm_next = (in_op == OP_RAMP) ? rpm_prod[RPM_SHIFT +: 17] : 17'd0;
            rep_next = (in_op == OP_RAMP) && (tgt_reg != 10'd0);
        end

        if (cmd.apply_simple && op_reg == OP_BYTE) begin
            if (pos == 3'(MODE_POS)) begin
                mode_next = byte_reg;
            end else if (pos < 3'(MODE_POS)) begin
                dig_next[pos] = to_digit(byte_reg);
            end else begin
                dig_next[3'(pos - 3'd1)] = to_digit(byte_reg);
            end
            pos_next = pos_inc;
            if (pos_inc == 3'(COMMAND_LENGTH)) begin
                tgt_next = 10'({6'd0, dig_next[0]} * 10'd100 + {6'd0, dig_next[1]} * 10'd10
                          + {6'd0, dig_next[2]});
                len_next = 10'({6'd0, dig_next[3]} * 10'd100 + {6'd0, dig_next[4]} * 10'd10
                          + {6'd0, dig_next[5]});
                if (mode_next == MODE_RIGHT || mode_next == MODE_LEFT) begin
                    ramp_next = '0;
                end
                pos_next = 3'd0;
            end
        end

        if (cmd.apply_simple && op_reg == OP_MS) begin
            if (!act_reg) begin
                if (gap_reg) begin
                    gap_next = 1'b0;
                end else if (mode_reg == MODE_RIGHT || mode_reg == MODE_LEFT
                             || (mode_reg == MODE_STOP && ramp_reg >= STOP_FLOOR)) begin
                    act_next = 1'b1;
                    rev_next = (mode_reg != MODE_RIGHT);
                    ph_next = 2'd0;
                    coil_next = coil_for(2'd0, rev_next);
                    hold_next = hold_val;
                    run = 1'b1;
                end else if (mode_reg == MODE_STOP) begin
                    coil_next = 4'd0;
                end
            end else begin
                run = 1'b1;
            end
            if (run) begin
                if (hold_next > 8'd0) begin
                    hold_next = hold_next - 8'd1;
                end
                if (hold_next == 8'd0) begin
                    if (ph_next == 2'd3) begin
                        act_next = 1'b0;
                        gap_next = 1'b1;
                        ph_next = 2'd0;
                    end else begin
                        ph_next = ph_next + 2'd1;
                        coil_next = coil_for(ph_next, rev_next);
                        hold_next = hold_val;
                    end
                end
            end
        end

        if (cmd.ramp_apply) begin
            move_next = 1'b0;
            if ({1'b0, tgt_reg} >= ramp_reg && mode_reg != MODE_STOP && mode_reg != MODE_NONE) begin
                ramp_next = 11'(ramp_reg + {1'b0, inc});
                move_next = 1'b1;
            end else if (ramp_reg >= STOP_FLOOR && mode_reg == MODE_STOP) begin
                ramp_next = (ramp_reg > {1'b0, inc}) ? 11'(ramp_reg - {1'b0, inc}) : 11'd0;
                move_next = 1'b1;
            end
            if (move_next) begin
                chg_next = chg_reg + 16'd1;
            end
            lo_next = 8'd0;
            hi_next = 8'(MAX_DELAY);
            cnt_next = 4'd0;
        end

        if (cmd.search_step) begin
            if (mid[7:0] == 8'd0 || IW'(DELAY_THR[mid[7:0]]) >= a_idx) begin
                lo_next = mid[7:0];
            end else begin
                hi_next = 8'(mid - 9'd1);
            end
            cnt_next = cnt_reg + 4'd1;
        end

        if (cmd.delay_apply && move_reg && ramp_reg != 11'd0) begin
            delay_next = (lo_reg == 8'd0) ? 8'd1 : lo_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
            for (int i = 0; i < 6; i++) begin
                dig_reg[i] <= '0;
            end
            mode_reg <= '0;
            tgt_reg <= '0;
            len_reg <= 10'd1;
            ramp_reg <= '0;
            delay_reg <= '0;
            chg_reg <= '0;
            ph_reg <= '0;
            hold_reg <= '0;
            act_reg <= 1'b0;
            gap_reg <= 1'b0;
            rev_reg <= 1'b0;
            coil_reg <= '0;
            cnt_reg <= '0;
            move_reg <= 1'b0;
        end else begin
            pos_reg <= pos_next;
            dig_reg <= dig_next;
            mode_reg <= mode_next;
            tgt_reg <= tgt_next;
            len_reg <= len_next;
            ramp_reg <= ramp_next;
            delay_reg <= delay_next;
            chg_reg <= chg_next;
            ph_reg <= ph_next;
            hold_reg <= hold_next;
            act_reg <= act_next;
            gap_reg <= gap_next;
            rev_reg <= rev_next;
            coil_reg <= coil_next;
            cnt_reg <= cnt_next;
            move_reg <= move_next;
        end
        op_reg <= op_next;
        byte_reg <= byte_next;
        rep_reg <= rep_next;
        rpm_reg <= rpm_next;
        lo_reg <= lo_next;
        hi_reg <= hi_next;
    end

    assign sts.op_is_ramp = (op_reg == OP_RAMP);
    assign sts.div_done = div_done;
    assign sts.search_done = (cnt_reg == 4'(SEARCH_STEPS));

    assign res_data = {mode_reg, chg_reg, rpm_reg, act_reg, coil_reg, delay_reg,
                       ramp_reg, len_reg, tgt_reg};
    assign res_report = rep_reg;
endmodule

// ===== rtl/stepper_speed_ramp_controller_top.sv =====
// Channel   Direction  Handshake             Payload
// s_axis    in         s_tvalid / s_tready   s_tdata: rx_byte, pulse_count; s_tuser: op
// m_axis    out        m_tvalid / m_tready   m_tdata: result fields; m_tuser: report_valid
//
// A command byte, millisecond tick or unused op goes through dispatch to done.
// A ramp tick adds a 10-step divider pass for speed over length and an
// 8-step binary search of the delay thresholds; rpm comes from a multiply at accept.
// One item is in work at a time; the next is accepted while a result waits in the
// output register. Reset is synchronous, active low, and needs no clearing pass.
module stepper_speed_ramp_controller_top #(
    parameter int DELAY_TABLE_DEPTH = sspr_pkg::DELAY_TABLE_DEPTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [23:0]                         s_tdata,  // rx_byte, pulse_count
    input  logic [1:0]                          s_tuser,  // op
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // target_speed, ramp_length, current_ramp_speed, step_delay_ms, coil_drive,
    // step_active, measured_rpm, ramp_change_count, mode_code, zero padding
    output logic [sspr_pkg::TDATA_OUT_W-1:0]    m_tdata,
    output logic                                m_tuser   // report_valid
);
    import sspr_pkg::*;

    cmd_t             cmd;
    sts_t             sts;
    logic             out_load;
    logic             out_free;
    logic [RES_W-1:0] res_data;
    logic             res_report;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [RES_W-1:0] m_data_reg;
    logic             m_user_reg;

    assign out_free = !m_tvalid_reg || m_tready;

    sspr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_valid(s_tvalid),
        .out_free(out_free),
        .sts     (sts),
        .in_ready(s_tready),
        .out_load(out_load),
        .cmd     (cmd)
    );

    sspr_dpath #(.DELAY_TABLE_DEPTH(DELAY_TABLE_DEPTH)) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .in_op     (s_tuser),
        .in_byte   (s_tdata[7:0]),
        .in_pulses (s_tdata[23:8]),
        .res_data  (res_data),
        .res_report(res_report)
    );

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
        if (out_load) begin
            m_data_reg <= res_data;
            m_user_reg <= res_report;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata = {(TDATA_OUT_W - RES_W)'(0), m_data_reg};
    assign m_tuser = m_user_reg;
endmodule
